### src/reverse_cholesky_with_zero_guard_assert.svh
// assertion macros shared by the reverse cholesky block
`ifndef REVERSE_CHOLESKY_WITH_ZERO_GUARD_ASSERT_SVH
`define REVERSE_CHOLESKY_WITH_ZERO_GUARD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCZ_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("rcz same-cycle check failed");

// next-cycle implication, checked out of reset
`define RCZ_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("rcz next-cycle check failed");

`endif

### src/rcz_pkg.sv
// shared types and constants of the reverse cholesky block
package rcz_pkg;

    localparam int CFG_SIZE_W = 4;
    localparam int CFG_THR_W  = 17;
    localparam int CFG_DATA_W = 17;

    localparam logic CFG_MATRIX_SIZE    = 1'b0;
    localparam logic CFG_ZERO_THRESHOLD = 1'b1;

    localparam logic [1:0] KIND_ENTRY     = 2'd0;
    localparam logic [1:0] KIND_NEAR_ZERO = 2'd1;
    localparam logic [1:0] KIND_FAIL      = 2'd2;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_RUN_START  = 5'd1,
        OP_MAT_RD     = 5'd2,
        OP_MAC_RD     = 5'd3,
        OP_MAC_MUL    = 5'd4,
        OP_MAC_ACC    = 5'd5,
        OP_REM        = 5'd6,
        OP_DIAG_ZERO  = 5'd7,
        OP_SQRT_START = 5'd8,
        OP_SQRT_WR    = 5'd9,
        OP_DIV_START  = 5'd10,
        OP_DIV_WR     = 5'd11,
        OP_ZDIV_WR    = 5'd12,
        OP_ENT_RD     = 5'd13,
        OP_OUT_REP    = 5'd14,
        OP_OUT_FAIL   = 5'd15,
        OP_OUT_ENT    = 5'd16
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic mag_small;
        logic rem_neg;
        logic d_zero;
        logic unit_busy;
        logic out_full;
    } dp_status_t;

endpackage

### src/rcz_ram.sv
// generic simple dual-port ram with registered read
module rcz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/rcz_dp.sv
// datapath: stores, multiply-accumulate, root and divide units, output register
`include "reverse_cholesky_with_zero_guard_assert.svh"
module rcz_dp import rcz_pkg::*; #(
    parameter int MAX_SIZE  = 8,
    parameter int FRAC_BITS = 16,
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
    localparam int RCW = $clog2(MAX_SIZE + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_en,
    input  logic [2:0]            element_row,
    input  logic [2:0]            element_col,
    input  logic signed [31:0]    element_value,
    input  logic [CFG_THR_W-1:0]  cfg_thr,
    input  dp_cmd_t               cmd,
    input  logic [IW-1:0]         row,
    input  logic [IW-1:0]         col,
    input  logic [IW-1:0]         k,
    input  logic [IW-1:0]         rep_idx,
    output dp_status_t            status,
    output logic [RCW-1:0]        rep_cnt,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            record_kind,
    output logic [2:0]            out_row,
    output logic [2:0]            out_col,
    output logic signed [31:0]    out_value,
    output logic                  last_record
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUMW  = 67 - FRAC_BITS;
    localparam int RADW  = ((31 + FRAC_BITS) % 2 == 0) ? (31 + FRAC_BITS) : (32 + FRAC_BITS);
    localparam int RTW   = RADW / 2;
    localparam int SCW   = $clog2(RTW + 1);
    localparam int QW    = 32 + FRAC_BITS;
    localparam int DCW   = $clog2(QW + 1);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // store ports
    logic [AW-1:0] mat_waddr, rc_addr, kc_addr, kr_addr, fa_raddr;
    logic          mat_re, fa_re, fb_re, fac_we;
    logic [31:0]   mat_rdata, fa_rdata, fb_rdata, fac_wdata;

    // arithmetic registers
    logic signed [63:0]     prod_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [31:0]     rem_reg;
    logic [31:0]            d_reg;
    logic [RCW-1:0]         rep_cnt_reg, rep_cnt_next;
    logic [2:0]             rep_row_reg [MAX_SIZE];
    logic signed [31:0]     rep_val_reg [MAX_SIZE];

    // root unit
    logic [RADW-1:0]  sq_x_reg;
    logic [RTW-1:0]   sq_root_reg;
    logic [RTW:0]     sq_rem_reg;
    logic [SCW-1:0]   sq_cnt_reg, sq_cnt_next;
    logic [RTW+2:0]   sq_t, sq_trial;

    // divide unit
    logic [QW-1:0]    dv_n_reg;
    logic [31:0]      dv_r_reg;
    logic             dv_neg_reg;
    logic [DCW-1:0]   dv_cnt_reg, dv_cnt_next;
    logic [32:0]      dv_t;
    logic [31:0]      div_val;

    // output register
    logic out_valid_reg, out_valid_next, out_load;

    logic signed [63:0]   prod;
    logic signed [63:0]   rnd;
    logic signed [SUMW:0] diff;
    logic signed [31:0]   rem_sat;
    logic [31:0]          mag;

    assign mat_waddr = AW'(int'(element_row) * MAX_SIZE + int'(element_col));
    assign rc_addr   = AW'(int'(row) * MAX_SIZE + int'(col));
    assign kc_addr   = AW'(int'(k) * MAX_SIZE + int'(col));
    assign kr_addr   = AW'(int'(k) * MAX_SIZE + int'(row));
    assign mat_re    = (cmd.op == OP_MAT_RD);
    assign fa_re     = (cmd.op == OP_MAC_RD) || (cmd.op == OP_ENT_RD);
    assign fb_re     = (cmd.op == OP_MAC_RD);
    assign fa_raddr  = (cmd.op == OP_MAC_RD) ? kc_addr : rc_addr;
    assign fac_we    = (cmd.op == OP_DIAG_ZERO) || (cmd.op == OP_SQRT_WR) ||
                       (cmd.op == OP_DIV_WR) || (cmd.op == OP_ZDIV_WR);

    always_comb
    begin
        case (cmd.op)
            OP_DIAG_ZERO: fac_wdata = 32'(cfg_thr);
            OP_SQRT_WR:   fac_wdata = 32'(sq_root_reg);
            OP_DIV_WR:    fac_wdata = div_val;
            OP_ZDIV_WR:
            begin
                if (rem_reg > 0)
                    fac_wdata = Q_MAX;
                else if (rem_reg < 0)
                    fac_wdata = Q_MIN;
                else
                    fac_wdata = 32'd0;
            end
            default:      fac_wdata = 32'd0;
        endcase
    end

    rcz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mat_ram (
        .clk   (clk),
        .we    (load_en && (element_col <= element_row) && (int'(element_row) < MAX_SIZE)),
        .waddr (mat_waddr),
        .wdata (element_value),
        .re    (mat_re),
        .raddr (rc_addr),
        .rdata (mat_rdata)
    );

    // two copies of the factor store give two reads a cycle
    rcz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fac_a_ram (
        .clk   (clk),
        .we    (fac_we),
        .waddr (rc_addr),
        .wdata (fac_wdata),
        .re    (fa_re),
        .raddr (fa_raddr),
        .rdata (fa_rdata)
    );

    rcz_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fac_b_ram (
        .clk   (clk),
        .we    (fac_we),
        .waddr (rc_addr),
        .wdata (fac_wdata),
        .re    (fb_re),
        .raddr (kr_addr),
        .rdata (fb_rdata)
    );

    // product, rounding and remainder
    assign prod = $signed(fa_rdata) * $signed(fb_rdata);
    assign rnd  = (prod_reg + HALF) >>> FRAC_BITS;
    assign diff = (SUMW + 1)'($signed(mat_rdata)) - (SUMW + 1)'(sum_reg);

    always_comb
    begin
        if ((&diff[SUMW:31]) || !(|diff[SUMW:31]))
            rem_sat = diff[31:0];
        else if (diff[SUMW])
            rem_sat = Q_MIN;
        else
            rem_sat = Q_MAX;
    end

    assign mag = rem_reg[31] ? 32'(~rem_reg + 32'sd1) : 32'(rem_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MAC_MUL)
            prod_reg <= prod;
        if (cmd.op == OP_MAT_RD)
            sum_reg <= '0;
        else if (cmd.op == OP_MAC_ACC)
            sum_reg <= sum_reg + SUMW'(rnd);
        if (cmd.op == OP_REM)
            rem_reg <= rem_sat;
        if (cmd.op == OP_DIAG_ZERO)
            d_reg <= 32'(cfg_thr);
        else if (cmd.op == OP_SQRT_WR)
            d_reg <= 32'(sq_root_reg);
        if ((cmd.op == OP_DIAG_ZERO) && (int'(rep_cnt_reg) < MAX_SIZE))
        begin
            rep_row_reg[rep_cnt_reg[IW-1:0]] <= 3'(row);
            rep_val_reg[rep_cnt_reg[IW-1:0]] <= rem_reg;
        end
    end

    always_comb
    begin
        rep_cnt_next = rep_cnt_reg;
        if (cmd.op == OP_RUN_START)
            rep_cnt_next = '0;
        else if ((cmd.op == OP_DIAG_ZERO) && (int'(rep_cnt_reg) < MAX_SIZE))
            rep_cnt_next = rep_cnt_reg + RCW'(1);
    end

    // root: two radicand bits a step
    assign sq_t     = {sq_rem_reg, sq_x_reg[RADW-1 -: 2]};
    assign sq_trial = {1'b0, sq_root_reg, 2'b01};

    always_comb
    begin
        sq_cnt_next = sq_cnt_reg;
        if (cmd.op == OP_SQRT_START)
            sq_cnt_next = SCW'(RTW);
        else if (sq_cnt_reg != '0)
            sq_cnt_next = sq_cnt_reg - SCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SQRT_START)
        begin
            sq_x_reg    <= RADW'(rem_reg[30:0]) << FRAC_BITS;
            sq_root_reg <= '0;
            sq_rem_reg  <= '0;
        end
        else if (sq_cnt_reg != '0)
        begin
            sq_x_reg <= sq_x_reg << 2;
            if (sq_t >= sq_trial)
            begin
                sq_rem_reg  <= (RTW + 1)'(sq_t - sq_trial);
                sq_root_reg <= {sq_root_reg[RTW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg  <= (RTW + 1)'(sq_t);
                sq_root_reg <= {sq_root_reg[RTW-2:0], 1'b0};
            end
        end
    end

    // divide: restoring, one quotient bit a step on magnitudes
    assign dv_t = {dv_r_reg, dv_n_reg[QW-1]};

    always_comb
    begin
        dv_cnt_next = dv_cnt_reg;
        if (cmd.op == OP_DIV_START)
            dv_cnt_next = DCW'(QW);
        else if (dv_cnt_reg != '0)
            dv_cnt_next = dv_cnt_reg - DCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_START)
        begin
            dv_n_reg   <= QW'(mag) << FRAC_BITS;
            dv_r_reg   <= '0;
            dv_neg_reg <= rem_reg[31];
        end
        else if (dv_cnt_reg != '0)
        begin
            if (dv_t >= {1'b0, d_reg})
            begin
                dv_r_reg <= 32'(dv_t - {1'b0, d_reg});
                dv_n_reg <= {dv_n_reg[QW-2:0], 1'b1};
            end
            else
            begin
                dv_r_reg <= dv_t[31:0];
                dv_n_reg <= {dv_n_reg[QW-2:0], 1'b0};
            end
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        if (!dv_neg_reg)
            div_val = (|dv_n_reg[QW-1:31]) ? Q_MAX : dv_n_reg[31:0];
        else if ((|dv_n_reg[QW-1:32]) || (dv_n_reg[31] && (|dv_n_reg[30:0])))
            div_val = Q_MIN;
        else
            div_val = ~dv_n_reg[31:0] + 32'd1;
    end

    // output register
    assign out_load = (cmd.op == OP_OUT_REP) || (cmd.op == OP_OUT_FAIL) ||
                      (cmd.op == OP_OUT_ENT);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_OUT_REP:
            begin
                record_kind <= KIND_NEAR_ZERO;
                out_row     <= rep_row_reg[rep_idx];
                out_col     <= rep_row_reg[rep_idx];
                out_value   <= rep_val_reg[rep_idx];
                last_record <= 1'b0;
            end
            OP_OUT_FAIL:
            begin
                record_kind <= KIND_FAIL;
                out_row     <= 3'(row);
                out_col     <= 3'(row);
                out_value   <= rem_reg;
                last_record <= 1'b1;
            end
            OP_OUT_ENT:
            begin
                record_kind <= KIND_ENTRY;
                out_row     <= 3'(row);
                out_col     <= 3'(col);
                out_value   <= $signed(fa_rdata);
                last_record <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
            dv_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rep_cnt_reg   <= rep_cnt_next;
            sq_cnt_reg    <= sq_cnt_next;
            dv_cnt_reg    <= dv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign rep_cnt          = rep_cnt_reg;
    assign status.mag_small = (mag < 32'(cfg_thr));
    assign status.rem_neg   = rem_reg[31];
    assign status.d_zero    = (d_reg == 32'd0);
    assign status.unit_busy = (sq_cnt_reg != '0) || (dv_cnt_reg != '0);
    assign status.out_full  = out_valid_reg;

    `RCZ_ASSERT_IMP(a_out_load_free, clk, rst_n, out_load, !out_valid_reg)
    `RCZ_ASSERT_NXT(a_unit_busy_after_start, clk, rst_n, cmd.op == OP_SQRT_START || cmd.op == OP_DIV_START, sq_cnt_reg != '0 || dv_cnt_reg != '0)

endmodule

### src/rcz_ctrl.sv
// controller: sequences the factor loops and the record emission
`include "reverse_cholesky_with_zero_guard_assert.svh"
module rcz_ctrl import rcz_pkg::*; #(
    parameter int MAX_SIZE = 8,
    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
    localparam int RCW = $clog2(MAX_SIZE + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  last_element,
    output logic                  in_ready,
    input  logic [CFG_SIZE_W-1:0] cfg_size,
    output dp_cmd_t               cmd,
    output logic [IW-1:0]         row,
    output logic [IW-1:0]         col,
    output logic [IW-1:0]         k,
    output logic [IW-1:0]         rep_idx,
    input  dp_status_t            status,
    input  logic [RCW-1:0]        rep_cnt
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_MAT  = 14'b00000000000010,
        S_MRD  = 14'b00000000000100,
        S_MMUL = 14'b00000000001000,
        S_MACC = 14'b00000000010000,
        S_REM  = 14'b00000000100000,
        S_DEC  = 14'b00000001000000,
        S_SQRT = 14'b00000010000000,
        S_DIV  = 14'b00000100000000,
        S_NEXT = 14'b00001000000000,
        S_REP  = 14'b00010000000000,
        S_FAIL = 14'b00100000000000,
        S_ERD  = 14'b01000000000000,
        S_ELD  = 14'b10000000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [IW-1:0]  row_reg, row_next, col_reg, col_next, k_reg, k_next;
    logic [IW-1:0]  nm1_reg, nm1_next, size_m1;
    logic [RCW-1:0] e_reg, e_next;
    logic           fail_reg, fail_next;
    logic           start;

    // order in use, clamped to the store
    always_comb
    begin
        if (cfg_size == '0)
            size_m1 = '0;
        else if (int'(cfg_size) > MAX_SIZE)
            size_m1 = IW'(MAX_SIZE - 1);
        else
            size_m1 = IW'(cfg_size - CFG_SIZE_W'(1));
    end

    assign in_ready = (state_reg == S_IDLE);
    assign start    = in_valid && in_ready && last_element;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        nm1_next   = nm1_reg;
        e_next     = e_reg;
        fail_next  = fail_reg;
        cmd.op     = OP_NONE;
        cmd.last   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_RUN_START;
                    nm1_next   = size_m1;
                    row_next   = size_m1;
                    col_next   = size_m1;
                    fail_next  = 1'b0;
                    state_next = S_MAT;
                end
            end
            S_MAT:
            begin
                cmd.op     = OP_MAT_RD;
                k_next     = nm1_reg;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                if (k_reg > row_reg)
                begin
                    cmd.op     = OP_MAC_RD;
                    state_next = S_MMUL;
                end
                else
                begin
                    state_next = S_REM;
                end
            end
            S_MMUL:
            begin
                cmd.op     = OP_MAC_MUL;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                cmd.op     = OP_MAC_ACC;
                k_next     = k_reg - IW'(1);
                state_next = S_MRD;
            end
            S_REM:
            begin
                cmd.op     = OP_REM;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (col_reg == row_reg)
                begin
                    if (status.mag_small)
                    begin
                        cmd.op     = OP_DIAG_ZERO;
                        state_next = S_NEXT;
                    end
                    else if (status.rem_neg)
                    begin
                        fail_next  = 1'b1;
                        e_next     = '0;
                        state_next = S_REP;
                    end
                    else
                    begin
                        cmd.op     = OP_SQRT_START;
                        state_next = S_SQRT;
                    end
                end
                else if (status.d_zero)
                begin
                    cmd.op     = OP_ZDIV_WR;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_DIV;
                end
            end
            S_SQRT:
            begin
                if (!status.unit_busy)
                begin
                    cmd.op     = OP_SQRT_WR;
                    state_next = S_NEXT;
                end
            end
            S_DIV:
            begin
                if (!status.unit_busy)
                begin
                    cmd.op     = OP_DIV_WR;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (col_reg != '0)
                begin
                    col_next   = col_reg - IW'(1);
                    state_next = S_MAT;
                end
                else if (row_reg != '0)
                begin
                    row_next   = row_reg - IW'(1);
                    col_next   = row_reg - IW'(1);
                    state_next = S_MAT;
                end
                else
                begin
                    e_next     = '0;
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                if (e_reg == rep_cnt)
                begin
                    if (fail_reg)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        state_next = S_ERD;
                    end
                end
                else if (!status.out_full)
                begin
                    cmd.op = OP_OUT_REP;
                    e_next = e_reg + RCW'(1);
                end
            end
            S_FAIL:
            begin
                if (!status.out_full)
                begin
                    cmd.op     = OP_OUT_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_ERD:
            begin
                cmd.op     = OP_ENT_RD;
                state_next = S_ELD;
            end
            S_ELD:
            begin
                if (!status.out_full)
                begin
                    cmd.op   = OP_OUT_ENT;
                    cmd.last = (row_reg == nm1_reg) && (col_reg == row_reg);
                    if (col_reg == row_reg)
                    begin
                        if (row_reg == nm1_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            row_next   = row_reg + IW'(1);
                            col_next   = '0;
                            state_next = S_ERD;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + IW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
            nm1_reg   <= '0;
            e_reg     <= '0;
            fail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
            nm1_reg   <= nm1_next;
            e_reg     <= e_next;
            fail_reg  <= fail_next;
        end
    end

    assign row     = row_reg;
    assign col     = col_reg;
    assign k       = k_reg;
    assign rep_idx = e_reg[IW-1:0];

    `RCZ_ASSERT_IMP(a_wr_after_unit_done, clk, rst_n, cmd.op == OP_SQRT_WR || cmd.op == OP_DIV_WR, !status.unit_busy)
    `RCZ_ASSERT_NXT(a_start_blocks_input, clk, rst_n, start, !in_ready)

endmodule

### src/reverse_cholesky_with_zero_guard.sv
// top level of the reverse cholesky factor block with near-zero guard
// usage:
//   load items (element_row, element_col, element_value, last_element) move on
//   in_valid/in_ready; each writes one lower-triangle element in Q16.16.
//   an item with last_element set starts a run that factors A = L^T L from the
//   last row up; in_ready stays low until all records of the run are handed
//   to the output register.
//   records leave on out_valid/out_ready: near-zero reports first, then
//   either a failure record or every factor entry in row-major order; the
//   final record of a run carries last_record.
// timing:
//   a run spends setup on each element, about n^3/6 multiply-accumulates,
//   a root per diagonal and a restoring divide per off-diagonal entry, plus
//   the emission of each entry; the iterative root and divide units set the
//   run length.
// a stalled receiver holds the output register and pauses the emission.
// reset clears the control state and restores matrix_size 8, threshold 7.
// configuration writes take effect at once; the user must make them only
// while idle, since the block itself does not enforce it.
module reverse_cholesky_with_zero_guard import rcz_pkg::*; #(
    parameter int MAX_SIZE  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            element_row,
    input  logic [2:0]            element_col,
    input  logic signed [31:0]    element_value,
    input  logic                  last_element,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            record_kind,
    output logic [2:0]            out_row,
    output logic [2:0]            out_col,
    output logic signed [31:0]    out_value,
    output logic                  last_record
);

    localparam int IW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int RCW = $clog2(MAX_SIZE + 1);

    // configuration registers
    logic [CFG_SIZE_W-1:0] size_reg, size_next;
    logic [CFG_THR_W-1:0]  thr_reg, thr_next;

    // controller to datapath
    dp_cmd_t        cmd;
    dp_status_t     status;
    logic [IW-1:0]  row, col, k, rep_idx;
    logic [RCW-1:0] rep_cnt;

    always_comb
    begin
        size_next = size_reg;
        thr_next  = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATRIX_SIZE:    size_next = cfg_wdata[CFG_SIZE_W-1:0];
                CFG_ZERO_THRESHOLD: thr_next  = cfg_wdata[CFG_THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= CFG_SIZE_W'(8);
            thr_reg  <= CFG_THR_W'(7);
        end
        else
        begin
            size_reg <= size_next;
            thr_reg  <= thr_next;
        end
    end

    // sequencer: loop counters and run phases
    rcz_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last_element (last_element),
        .in_ready     (in_ready),
        .cfg_size     (size_reg),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .k            (k),
        .rep_idx      (rep_idx),
        .status       (status),
        .rep_cnt      (rep_cnt)
    );

    // stores, arithmetic units and the output register
    rcz_dp #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_en       (in_valid && in_ready),
        .element_row   (element_row),
        .element_col   (element_col),
        .element_value (element_value),
        .cfg_thr       (thr_reg),
        .cmd           (cmd),
        .row           (row),
        .col           (col),
        .k             (k),
        .rep_idx       (rep_idx),
        .status        (status),
        .rep_cnt       (rep_cnt),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .record_kind   (record_kind),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last_record   (last_record)
    );

endmodule
